// File: design/wrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wrhp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] HDR_LAST_IDX  = 32'd11;
    localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
    localparam logic [31:0] CHDR_LAST_IDX = 32'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_TAG   = 3'd2;
    localparam logic [2:0] ST_NOT_PCM   = 3'd3;
    localparam logic [2:0] ST_NO_FMT    = 3'd4;
    localparam logic [2:0] ST_NO_DATA   = 3'd5;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CHDR    = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_PAD     = 6'b001000,
        PH_BADTAG  = 6'b010000,
        PH_NOTPCM  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rate_hz;
        logic [15:0] channels;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_length;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/wrhp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module wrhp_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wrhp_pkg::t_in_item i_in_item,
    input  logic               i_out_full,
    output logic               o_fire,
    output wrhp_pkg::t_in_item o_item
);
    import wrhp_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_fire;

    assign w_fire     = r_valid && !(r_item.is_last && i_out_full);
    assign o_in_stall = r_valid && !w_fire;
    assign o_fire     = w_fire;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || w_fire) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_valid || w_fire) && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

endmodule

`default_nettype wire

// File: design/wrhp_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none

module wrhp_parse_core #(
    parameter int COUNT_WIDTH = wrhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  wrhp_pkg::t_in_item  i_item,
    output logic                o_result_valid,
    output wrhp_pkg::t_out_item o_result
);
    import wrhp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [31:0]            r_fcnt, n_fcnt;
    logic [31:0]            r_tag, n_tag;
    logic [31:0]            r_len, n_len;
    logic [31:0]            r_pend_lo, n_pend_lo;
    logic [15:0]            r_pend_ch, n_pend_ch;
    logic [15:0]            r_pend_bits, n_pend_bits;
    logic [31:0]            r_k_rate, n_k_rate;
    logic [15:0]            r_k_ch, n_k_ch;
    logic [15:0]            r_k_bits, n_k_bits;
    logic [31:0]            r_k_off, n_k_off;
    logic [31:0]            r_k_len, n_k_len;
    logic                   r_fl_fmt, n_fl_fmt;
    logic                   r_fl_data, n_fl_data;
    logic                   r_fl_nonpcm, n_fl_nonpcm;
    logic                   r_fl_badriff, n_fl_badriff;

    logic [COUNT_WIDTH-1:0] w_pos_next;
    logic [31:0]            w_pos_lo;
    logic [7:0]             w_b;
    logic [31:0]            w_k;
    logic [31:0]            w_k_inc;
    logic                   w_done;
    logic                   w_fmt_ok;
    t_out_item              w_res;

    assign w_pos_next = (r_pos == {COUNT_WIDTH{1'b1}}) ? r_pos : r_pos + COUNT_WIDTH'(1);
    assign w_pos_lo   = 32'(w_pos_next);
    assign w_b        = i_item.byte_in;
    assign w_k        = r_fcnt;
    assign w_k_inc    = r_fcnt + 32'd1;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = w_pos_next;
        n_fcnt       = r_fcnt;
        n_tag        = r_tag;
        n_len        = r_len;
        n_pend_lo    = r_pend_lo;
        n_pend_ch    = r_pend_ch;
        n_pend_bits  = r_pend_bits;
        n_k_rate     = r_k_rate;
        n_k_ch       = r_k_ch;
        n_k_bits     = r_k_bits;
        n_k_off      = r_k_off;
        n_k_len      = r_k_len;
        n_fl_fmt     = r_fl_fmt;
        n_fl_data    = r_fl_data;
        n_fl_nonpcm  = r_fl_nonpcm;
        n_fl_badriff = r_fl_badriff;
        w_done       = 1'b0;
        w_fmt_ok     = 1'b0;
        w_res        = '0;

        case (r_phase)
            PH_HEADER: begin
                if (w_k < 32'd4 || w_k >= 32'd8) begin
                    n_tag = {r_tag[23:0], w_b};
                end
                if (w_k == 32'd3 && n_tag != TAG_RIFF) begin
                    n_fl_badriff = 1'b1;
                end
                n_fcnt = w_k_inc;
                if (w_k == HDR_LAST_IDX) begin
                    n_phase = (n_fl_badriff || n_tag != TAG_WAVE) ? PH_BADTAG : PH_CHDR;
                    n_fl_fmt     = 1'b0;
                    n_fl_data    = 1'b0;
                    n_fl_nonpcm  = 1'b0;
                    n_fl_badriff = 1'b0;
                    n_fcnt       = '0;
                end
            end
            PH_CHDR: begin
                if (w_k < 32'd4) begin
                    n_tag = {r_tag[23:0], w_b};
                end else begin
                    case (w_k[1:0])
                        2'd0:    n_len[7:0]   = w_b;
                        2'd1:    n_len[15:8]  = w_b;
                        2'd2:    n_len[23:16] = w_b;
                        default: n_len[31:24] = w_b;
                    endcase
                end
                if (w_k == 32'd0) begin
                    n_len = '0;
                end
                n_fcnt = w_k_inc;
                if (w_k == CHDR_LAST_IDX) begin
                    n_fcnt      = '0;
                    n_fl_nonpcm = 1'b0;
                    n_pend_lo   = (n_tag == TAG_DATA) ? w_pos_lo : 32'd0;
                    n_pend_ch   = '0;
                    n_pend_bits = '0;
                    if (n_len == 32'd0) begin
                        w_done = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (r_tag == TAG_FMT) begin
                    if ((w_k == 32'd0 && w_b != 8'd1) || (w_k == 32'd1 && w_b != 8'd0)) begin
                        n_fl_nonpcm = 1'b1;
                    end else if (w_k == 32'd2) begin
                        n_pend_ch[7:0] = w_b;
                    end else if (w_k == 32'd3) begin
                        n_pend_ch[15:8] = w_b;
                    end else if (w_k >= 32'd4 && w_k <= 32'd7) begin
                        case (w_k[1:0])
                            2'd0:    n_pend_lo[7:0]   = w_b;
                            2'd1:    n_pend_lo[15:8]  = w_b;
                            2'd2:    n_pend_lo[23:16] = w_b;
                            default: n_pend_lo[31:24] = w_b;
                        endcase
                    end else if (w_k == 32'd14) begin
                        n_pend_bits[7:0] = w_b;
                    end else if (w_k == 32'd15) begin
                        n_pend_bits[15:8] = w_b;
                    end
                end
                n_fcnt = w_k_inc;
                if (w_k_inc == r_len) begin
                    w_done = 1'b1;
                end
            end
            PH_PAD: begin
                n_phase = PH_CHDR;
                n_fcnt  = '0;
            end
            default: begin
            end
        endcase

        if (w_done) begin
            w_fmt_ok = (n_tag == TAG_FMT) && (n_len >= FMT_MIN_LEN);
            if (w_fmt_ok && n_fl_nonpcm) begin
                n_phase = PH_NOTPCM;
            end else begin
                if (w_fmt_ok) begin
                    n_k_rate = n_pend_lo;
                    n_k_ch   = n_pend_ch;
                    n_k_bits = n_pend_bits;
                    n_fl_fmt = 1'b1;
                end else if (n_tag == TAG_DATA) begin
                    n_k_off   = n_pend_lo;
                    n_k_len   = n_len;
                    n_fl_data = 1'b1;
                end
                n_phase = n_len[0] ? PH_PAD : PH_CHDR;
                n_fcnt  = '0;
            end
        end

        if (n_phase == PH_HEADER) begin
            w_res.status = ST_TOO_SHORT;
        end else if (n_phase == PH_BADTAG) begin
            w_res.status = ST_BAD_TAG;
        end else if (n_phase == PH_NOTPCM) begin
            w_res.status = ST_NOT_PCM;
        end else if (!n_fl_fmt) begin
            w_res.status = ST_NO_FMT;
        end else if (!n_fl_data) begin
            w_res.status = ST_NO_DATA;
        end else begin
            w_res.status      = ST_OK;
            w_res.rate_hz     = n_k_rate;
            w_res.channels    = n_k_ch;
            w_res.sample_bits = n_k_bits;
            w_res.data_offset = n_k_off;
            w_res.data_length = n_k_len;
        end

        if (i_item.is_last) begin
            n_phase      = PH_HEADER;
            n_pos        = '0;
            n_fcnt       = '0;
            n_fl_fmt     = 1'b0;
            n_fl_data    = 1'b0;
            n_fl_nonpcm  = 1'b0;
            n_fl_badriff = 1'b0;
        end
    end

    assign o_result_valid = i_fire && i_item.is_last;
    assign o_result       = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_fcnt       <= '0;
            r_fl_fmt     <= 1'b0;
            r_fl_data    <= 1'b0;
            r_fl_nonpcm  <= 1'b0;
            r_fl_badriff <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_fcnt       <= n_fcnt;
            r_fl_fmt     <= n_fl_fmt;
            r_fl_data    <= n_fl_data;
            r_fl_nonpcm  <= n_fl_nonpcm;
            r_fl_badriff <= n_fl_badriff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_tag       <= n_tag;
            r_len       <= n_len;
            r_pend_lo   <= n_pend_lo;
            r_pend_ch   <= n_pend_ch;
            r_pend_bits <= n_pend_bits;
            r_k_rate    <= n_k_rate;
            r_k_ch      <= n_k_ch;
            r_k_bits    <= n_k_bits;
            r_k_off     <= n_k_off;
            r_k_len     <= n_k_len;
        end
    end

    // The parser restarts at the RIFF header after every final byte.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.is_last) |=> (r_phase == PH_HEADER && r_pos == '0 && r_fcnt == '0))
        else $error("parser did not restart after the final byte");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_fcnt <= HDR_LAST_IDX && !r_fl_fmt && !r_fl_data))
        else $error("header phase count or flags out of range");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_fcnt < r_len))
        else $error("payload count reached the chunk length");

    a_pad_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD) |-> r_len[0])
        else $error("pad phase entered for an even chunk");

endmodule

`default_nettype wire

// File: design/wrhp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module wrhp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  wrhp_pkg::t_out_item i_result,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wrhp_pkg::t_out_item o_out_item
);
    import wrhp_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_full      = r_valid && i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: design/wav_riff_header_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream RIFF/WAVE PCM header parser. One file byte is taken per clock cycle;
// only a final byte waits, while the result register still holds an unaccepted
// status item. The is_last mark on a byte yields one status item through the input
// register and the result register; the parser then restarts for the next file.
// Each byte passes through an input register and one pass of the chunk walker,
// whose phase, counters and kept fields update once per byte. The result holds
// the last complete fmt and data chunks, with all fields zero on a failure status.
// The byte position counter is COUNT_WIDTH bits wide and saturates.

module wav_riff_header_parser_unit #(
    parameter int COUNT_WIDTH = wrhp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wrhp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wrhp_pkg::t_out_item o_out_item
);
    import wrhp_pkg::*;

    logic      w_fire;
    logic      w_out_full;
    logic      w_res_valid;
    t_in_item  w_item;
    t_out_item w_res;

    wrhp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_out_full (w_out_full),
        .o_fire     (w_fire),
        .o_item     (w_item)
    );

    wrhp_parse_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parse_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_item         (w_item),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    wrhp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_result    (w_res),
        .o_full      (w_out_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: tb/wav_riff_header_parser_unit_tb.sv
`timescale 1ns / 1ps

module wav_riff_header_parser_unit_tb;

    import wrhp_pkg::*;

    localparam int POS_W = COUNT_WIDTH_DEF;
    localparam int RUN_LIMIT = 400000;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    wav_riff_header_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial forever #4 i_clk = ~i_clk;

    int        mismatches = 0;
    int        cycle_count = 0;
    int        bytes_sent = 0;
    bit        in_gaps_on = 1'b1;
    bit        out_stall_on = 1'b1;
    t_out_item reports_due[$];
    logic [7:0] file_bytes[$];

    // Parser state as the block should hold it.
    t_phase           wav_phase;
    logic [POS_W-1:0] wav_pos;
    logic [31:0]      field_idx;
    logic [31:0]      cur_tag;
    logic [31:0]      cur_len;
    logic [63:0]      fmt_acc;
    logic [63:0]      fmt_kept;
    logic [63:0]      data_span;
    logic             seen_fmt;
    logic             seen_data;
    logic             fmt_not_pcm;
    logic             riff_bad;

    function automatic void clear_parser();
        wav_phase = PH_HEADER;
        wav_pos = '0;
        field_idx = '0;
        cur_tag = '0;
        cur_len = '0;
        fmt_acc = '0;
        fmt_kept = '0;
        data_span = '0;
        seen_fmt = 1'b0;
        seen_data = 1'b0;
        fmt_not_pcm = 1'b0;
        riff_bad = 1'b0;
    endfunction

    function automatic logic [POS_W-1:0] pos_after(input logic [POS_W-1:0] p);
        return (p == '1) ? p : p + 1'b1;
    endfunction

    function automatic void close_chunk();
        if (cur_tag == TAG_FMT && cur_len >= FMT_MIN_LEN) begin
            if (fmt_not_pcm) begin
                wav_phase = PH_NOTPCM;
                return;
            end
            fmt_kept = fmt_acc;
            seen_fmt = 1'b1;
        end else if (cur_tag == TAG_DATA) begin
            data_span = {cur_len, fmt_acc[31:0]};
            seen_data = 1'b1;
        end
        wav_phase = cur_len[0] ? PH_PAD : PH_CHDR;
        field_idx = '0;
    endfunction

    function automatic void parse_wav_byte(input t_in_item it, output bit done,
                                           output t_out_item rpt);
        logic [31:0] k;
        logic [7:0]  b;
        k = field_idx;
        b = it.byte_in;
        done = 1'b0;
        rpt = '0;
        case (wav_phase)
            PH_HEADER: begin
                if (k < 4 || k >= 8) cur_tag = {cur_tag[23:0], b};
                if (k == 3 && cur_tag != TAG_RIFF) riff_bad = 1'b1;
                field_idx = k + 1;
                if (k == HDR_LAST_IDX) begin
                    wav_phase = (riff_bad || cur_tag != TAG_WAVE) ? PH_BADTAG : PH_CHDR;
                    seen_fmt = 1'b0;
                    seen_data = 1'b0;
                    fmt_not_pcm = 1'b0;
                    riff_bad = 1'b0;
                    field_idx = '0;
                end
            end
            PH_CHDR: begin
                if (k < 4) cur_tag = {cur_tag[23:0], b};
                else cur_len = cur_len | (32'(b) << (8 * (k - 4)));
                if (k == 0) cur_len = '0;
                field_idx = k + 1;
                if (k == CHDR_LAST_IDX) begin
                    field_idx = '0;
                    fmt_not_pcm = 1'b0;
                    fmt_acc = (cur_tag == TAG_DATA) ? 64'(pos_after(wav_pos)) : 64'd0;
                    if (cur_len == 0) close_chunk();
                    else wav_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (cur_tag == TAG_FMT) begin
                    if ((k == 0 && b != 8'd1) || (k == 1 && b != 8'd0)) fmt_not_pcm = 1'b1;
                    else if (k >= 2 && k <= 3) fmt_acc[32 + 8 * (k - 2) +: 8] = b;
                    else if (k >= 4 && k <= 7) fmt_acc[8 * (k - 4) +: 8] = b;
                    else if (k >= 14 && k <= 15) fmt_acc[48 + 8 * (k - 14) +: 8] = b;
                end
                field_idx = k + 1;
                if (field_idx == cur_len) close_chunk();
            end
            PH_PAD: begin
                wav_phase = PH_CHDR;
                field_idx = '0;
            end
            default: begin
            end
        endcase
        wav_pos = pos_after(wav_pos);
        if (it.is_last) begin
            done = 1'b1;
            if (wav_phase == PH_HEADER) rpt.status = ST_TOO_SHORT;
            else if (wav_phase == PH_BADTAG) rpt.status = ST_BAD_TAG;
            else if (wav_phase == PH_NOTPCM) rpt.status = ST_NOT_PCM;
            else if (!seen_fmt) rpt.status = ST_NO_FMT;
            else if (!seen_data) rpt.status = ST_NO_DATA;
            else rpt.status = ST_OK;
            if (rpt.status == ST_OK) begin
                rpt.rate_hz = fmt_kept[31:0];
                rpt.channels = fmt_kept[47:32];
                rpt.sample_bits = fmt_kept[63:48];
                rpt.data_offset = data_span[31:0];
                rpt.data_length = data_span[63:32];
            end
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        bit        due;
        t_out_item rpt;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_wav_byte(i_in_item, due, rpt);
                if (due) reports_due.push_back(rpt);
            end
            if (o_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    $error("status item with no report due: status %0d", o_out_item.status);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", 32'(want.status), 32'(o_out_item.status));
                    check_field("rate_hz", want.rate_hz, o_out_item.rate_hz);
                    check_field("channels", 32'(want.channels), 32'(o_out_item.channels));
                    check_field("sample_bits", 32'(want.sample_bits),
                                32'(o_out_item.sample_bits));
                    check_field("data_offset", want.data_offset, o_out_item.data_offset);
                    check_field("data_length", want.data_length, o_out_item.data_length);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= out_stall_on && $urandom_range(0, 99) < 12;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("wav_riff_header_parser_unit_tb: errors");
            $finish;
        end
    end

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void put_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8 * i +: 8]);
    endfunction

    function automatic void put_fill(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_header(input logic [31:0] riff, input logic [31:0] wave);
        put_tag(riff);
        put_le($urandom, 4);
        put_tag(wave);
    endfunction

    function automatic void put_fmt(input int len, input logic [15:0] code,
                                    input logic [15:0] ch, input logic [31:0] rate,
                                    input logic [15:0] bits);
        put_tag(TAG_FMT);
        put_le(len, 4);
        put_le(32'(code), 2);
        put_le(32'(ch), 2);
        put_le(rate, 4);
        put_fill(6);
        put_le(32'(bits), 2);
        put_fill(len - 16);
        if (len % 2) put_fill(1);
    endfunction

    function automatic void put_plain(input logic [31:0] tag, input int len);
        put_tag(tag);
        put_le(len, 4);
        put_fill(len);
        if (len % 2) put_fill(1);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.byte_in = b;
        it.is_last = last;
        while (in_gaps_on && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic wait_reports_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (reports_due.size() != 0);
    endtask

    task automatic test_short_files();
        put_fill(1);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        void'(file_bytes.pop_back());
        send_file();
    endtask

    task automatic test_bad_tags();
        put_header(TAG_RIFF, TAG_WAVE);
        send_file();
        put_header(TAG_RIFF ^ 32'h0000_0001, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
        put_plain(TAG_DATA, 4);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE ^ 32'h8000_0000);
        put_fmt(16, 16'd1, 16'd1, 32'd8000, 16'd8);
        put_plain(TAG_DATA, 2);
        send_file();
    endtask

    task automatic test_pcm_fields();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_plain(TAG_DATA, 0);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd0, 32'd0, 16'd0);
        put_plain(TAG_DATA, 3);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_plain(TAG_LIST, 5);
        put_fmt(17, 16'd1, 16'd6, 32'd96000, 16'd24);
        put_plain(TAG_DATA, 2);
        put_plain(TAG_LIST, 1);
        send_file();
    endtask

    task automatic test_non_pcm();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd3, 16'd2, 32'd48000, 16'd32);
        put_plain(TAG_DATA, 4);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(18, 16'h0101, 16'd2, 32'd22050, 16'd16);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_plain(TAG_FMT, 14);
        put_fmt(16, 16'd1, 16'd1, 32'd11025, 16'd8);
        put_plain(TAG_DATA, 6);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd2, 32'd32000, 16'd16);
        put_plain(TAG_DATA, 1);
        put_fmt(16, 16'd2, 16'd2, 32'd32000, 16'd16);
        repeat (3) void'(file_bytes.pop_back());
        send_file();
    endtask

    task automatic test_missing_chunks();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_plain(TAG_DATA, 4);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_plain(TAG_FMT, 0);
        put_plain(TAG_DATA, 0);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd1, 32'd8000, 16'd8);
        put_plain(TAG_DATA, 2);
        put_fmt(20, 16'd1, 16'd4, 32'd192000, 16'd24);
        put_plain(TAG_DATA, 5);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd2, 32'd44100, 16'd16);
        put_plain(TAG_DATA, 3);
        put_tag(TAG_DATA);
        put_le(200, 4);
        put_fill(10);
        send_file();
        put_header(TAG_RIFF, TAG_WAVE);
        put_fmt(16, 16'd1, 16'd2, 32'd16000, 16'd16);
        put_plain(TAG_DATA, 1);
        put_tag(TAG_LIST);
        put_fill(2);
        send_file();
    endtask

    task automatic test_random_files();
        int          start_bytes;
        int          files;
        int          pick;
        int          cut;
        logic [31:0] riff;
        logic [31:0] wave;
        start_bytes = bytes_sent;
        files = 0;
        while (bytes_sent - start_bytes < 900 || files < 21) begin
            in_gaps_on = !(files >= 6 && files < 16);
            out_stall_on = in_gaps_on;
            if ($urandom_range(0, 99) < 12) begin
                if ($urandom_range(0, 1)) put_header(TAG_RIFF, TAG_WAVE);
                put_fill($urandom_range(1, 30));
            end else begin
                riff = TAG_RIFF;
                wave = TAG_WAVE;
                case ($urandom_range(0, 24))
                    0: riff ^= 32'd1 << $urandom_range(0, 31);
                    1: wave ^= 32'd1 << $urandom_range(0, 31);
                    default: begin
                    end
                endcase
                put_header(riff, wave);
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) begin
                        put_fmt((pick == 0) ? $urandom_range(17, 21) : 16,
                                ($urandom_range(0, 9) == 0) ?
                                    16'($urandom_range(0, 65535)) : 16'd1,
                                16'($urandom_range(0, 65535)), $urandom,
                                16'($urandom_range(0, 65535)));
                    end else if (pick < 7) begin
                        put_plain(TAG_DATA, $urandom_range(0, 9));
                    end else if (pick == 7) begin
                        put_plain(TAG_FMT, $urandom_range(0, 15));
                    end else if (pick == 8) begin
                        put_plain(TAG_FMT ^ (32'd1 << $urandom_range(0, 31)),
                                  $urandom_range(0, 6));
                    end else begin
                        put_plain($urandom, $urandom_range(0, 6));
                    end
                end
                if ($urandom_range(0, 99) < 15) begin
                    cut = $urandom_range(1, file_bytes.size());
                    while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                end
            end
            send_file();
            files++;
            if (files == 20 || $urandom_range(0, 99) < 4) wait_reports_drained();
        end
        in_gaps_on = 1'b1;
        out_stall_on = 1'b1;
    endtask

    initial begin
        clear_parser();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_files();
        test_bad_tags();
        test_pcm_fields();
        test_non_pcm();
        test_missing_chunks();
        test_random_files();
        wait_reports_drained();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("wav_riff_header_parser_unit_tb: clean");
        end else begin
            $display("wav_riff_header_parser_unit_tb: errors");
        end
        $finish;
    end

endmodule
